>>> rtl/tcos_pkg.sv
// Shared types and constants for the Taylor cosine pipeline.
// Holds the Q0.32 reciprocal table and the word type passed between stages.
// No dependencies.
package tcos_pkg;

	localparam int unsigned MAX_TERMS = 12;
	localparam int unsigned TERM_W    = 5;
	localparam int unsigned Y_W       = 35;
	localparam int unsigned P_W       = 64;

	localparam logic signed [P_W-1:0] ONE_Q28 = 64'sh0000_0000_1000_0000;

	// floor(2^32 / ((2i)(2i-1))) for i = 1..16, entry i-1
	localparam logic [31:0] R_TABLE [16] = '{
		32'd2147483648, 32'd357913941, 32'd143165576, 32'd76695844,
		32'd47721858,   32'd32537631,  32'd23598721,  32'd17895697,
		32'd14035840,   32'd11302545,  32'd9296466,   32'd7780737,
		32'd6607641,    32'd5681173,   32'd4936744,   32'd4329604
	};

	// one word in flight: y = x*x in Q7.28, p = Horner partial sum in Q35.28
	typedef struct packed {
		logic                    valid;
		logic [Y_W-1:0]          y;
		logic signed [P_W-1:0]   p;
	} tcos_item_t;

endpackage

>>> rtl/taylor_cosine.sv
// Top level of the Taylor cosine pipeline: square stage, term chain, output stage.
// Depends on tcos_pkg, tcos_square and tcos_term.
//
// Takes one angle (signed Q3.28) per clock and gives cos(angle) in Q3.28,
// saturated, after the registered square stage, one tcos_term per Horner
// term and a registered saturation stage. busy is never raised, and
// done pulses for one cycle with cosine; the receiver must take it then.
// num_terms is written through num_terms_we and must only change while no
// word is in flight; values above the term count act as the full count.
module taylor_cosine import tcos_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] angle,
	output logic               done,
	output logic signed [31:0] cosine,
	input  logic               num_terms_we,
	input  logic [3:0]         num_terms
);

	localparam int unsigned LATENCY = 4 * MAX_TERMS + 2;

	logic [3:0]        num_terms_q;
	logic [TERM_W-1:0] m_eff;
	tcos_item_t        chain [MAX_TERMS+1];
	logic [31:0]       recip [MAX_TERMS];
	logic signed [63:0] p_last;
	logic               done_q;
	logic signed [31:0] cosine_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_terms_q <= 4'd12;
		end else if (num_terms_we) begin
			num_terms_q <= num_terms;
		end
	end

	assign m_eff = ({1'b0, num_terms_q} > TERM_W'(MAX_TERMS)) ?
	               TERM_W'(MAX_TERMS) : {1'b0, num_terms_q};

	tcos_square u_square (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.angle  (angle),
		.item   (chain[0])
	);

	// stage k evaluates term i = MAX_TERMS - k; unused high terms get r = 0,
	// which leaves p at 1.0
	for (genvar k = 0; k < MAX_TERMS; k++) begin : g_term
		assign recip[k] = (TERM_W'(MAX_TERMS - k) <= m_eff) ?
		                  R_TABLE[MAX_TERMS-1-k] : 32'd0;

		tcos_term u_term (
			.clk      (clk),
			.arst_n   (arst_n),
			.item_in  (chain[k]),
			.recip    (recip[k]),
			.item_out (chain[k+1])
		);
	end

	assign p_last = chain[MAX_TERMS].p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain[MAX_TERMS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (p_last[63:31] == {33{p_last[63]}}) begin
			cosine_q <= p_last[31:0];
		end else if (p_last[63]) begin
			cosine_q <= 32'sh8000_0000;
		end else begin
			cosine_q <= 32'sh7FFF_FFFF;
		end
	end

	assign busy   = 1'b0;
	assign done   = done_q;
	assign cosine = cosine_q;

`ifndef NO_ASSERTIONS
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("done without matching start");
	a_no_terms: assert property (@(posedge clk) disable iff (!arst_n)
		(chain[MAX_TERMS].valid && m_eff == '0 && $stable(m_eff))
		|=> (cosine == 32'sh1000_0000))
		else $error("zero terms must give one");
`endif

endmodule

>>> rtl/tcos_square.sv
// Entry stage: squares the angle and seeds the Horner sum with 1.0.
// Depends on tcos_pkg.
module tcos_square import tcos_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] angle,
	output tcos_item_t         item
);

	logic               vld_s1;
	logic signed [63:0] sq_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		sq_s1 <= angle * angle;
	end

	// square is non-negative and at most 2^62, so a plain slice is the floor
	assign item.valid = vld_s1;
	assign item.y     = sq_s1[62:28];
	assign item.p     = ONE_Q28;

`ifndef NO_ASSERTIONS
	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid |-> (item.y <= 35'h4_0000_0000))
		else $error("square out of range");
`endif

endmodule

>>> rtl/tcos_term.sv
// One Horner step p' = 1 - floor(sat64(floor(y*p/2^28)) * r / 2^32), four stages.
// Wide products are split into partial products over 32-bit halves. Depends on tcos_pkg.
module tcos_term import tcos_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tcos_item_t  item_in,
	input  logic [31:0] recip,
	output tcos_item_t  item_out
);

	logic [3:0] vld_q;

	logic [Y_W-1:0]     y_s1, y_s2, y_s3, y_s4;
	logic [66:0]        pl_s1;
	logic signed [67:0] ph_s1;
	logic signed [63:0] t_s2;
	logic [63:0]        ql_s3;
	logic signed [64:0] qh_s3;
	logic signed [63:0] p_s4;

	logic signed [99:0] yp_full;
	logic signed [71:0] yp_sh;
	logic signed [63:0] t_sat;
	logic signed [96:0] tr_full;
	logic signed [63:0] u_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[2:0], item_in.valid};
		end
	end

	always_comb begin
		yp_full = $signed({ph_s1, 32'd0}) + $signed({33'd0, pl_s1});
		yp_sh   = yp_full[99:28];
		// saturate to 64 bits
		if (yp_sh[71:63] == {9{yp_sh[71]}}) begin
			t_sat = yp_sh[63:0];
		end else if (yp_sh[71]) begin
			t_sat = 64'sh8000_0000_0000_0000;
		end else begin
			t_sat = 64'sh7FFF_FFFF_FFFF_FFFF;
		end
		tr_full = $signed({qh_s3, 32'd0}) + $signed({33'd0, ql_s3});
		u_val   = tr_full[95:32];
	end

	always_ff @(posedge clk) begin
		y_s1  <= item_in.y;
		pl_s1 <= 67'(item_in.y) * 67'(item_in.p[31:0]);
		ph_s1 <= $signed({33'd0, item_in.y}) *
		         $signed({{36{item_in.p[63]}}, item_in.p[63:32]});
		y_s2  <= y_s1;
		t_s2  <= t_sat;
		y_s3  <= y_s2;
		ql_s3 <= 64'(t_s2[31:0]) * 64'(recip);
		qh_s3 <= $signed({{33{t_s2[63]}}, t_s2[63:32]}) * $signed({33'd0, recip});
		y_s4  <= y_s3;
		p_s4  <= ONE_Q28 - u_val;
	end

	assign item_out.valid = vld_q[3];
	assign item_out.y     = y_s4;
	assign item_out.p     = p_s4;

`ifndef NO_ASSERTIONS
	a_vld_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_out.valid |-> $past(item_in.valid, 4))
		else $error("term valid without entry");
`endif

endmodule
